/* hw/rtl/bssc_pkg.sv */
// ---------------------------------------------------------------------------
// Bit stream statistics collector package
// Operation codes, register indexes and register reset values shared by the
// collector RTL.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bssc_pkg;

  // Operation carried by each input item.
  typedef enum logic [1:0] {
    OP_PUSH         = 2'd0,
    OP_READ_PATTERN = 2'd1,
    OP_READ_LAG     = 2'd2,
    OP_READ_SUM     = 2'd3
  } op_t;

  // Register index, taken from bit 2 of the byte address.
  typedef enum logic {
    REG_PATTERN_LENGTH = 1'b0,
    REG_MAX_LAG        = 1'b1
  } reg_idx_t;

  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned OUT_BITS      = 32;

  localparam logic [3:0] PATTERN_LENGTH_RESET = 4'd8;
  localparam logic [4:0] MAX_LAG_RESET        = 5'd31;

endpackage

/* hw/rtl/bit_stream_statistics_collector.sv */
// A read item's result passes through the second stage registers into the
// result queue, from which it is taken. Throughput: one item per clock while
// in_stall is low; the pattern counter memory is updated by a registered
// read and a second stage write, with forwarding of the write in flight.
// Reset: synchronous, clears history, sum, total, lag counters and the
// per-entry valid bits of the pattern memory; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Bit stream statistics collector
// Keeps a pattern histogram, agree/disagree counters for every lag, a
// saturating +1/-1 sum and a bit total over a pushed bit stream, and
// answers read items for any of them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bit_stream_statistics_collector
  import bssc_pkg::*;
#(
  parameter int MAX_PATTERN_BITS = 8,
  parameter int MAX_LAG_LIMIT    = 31,
  parameter int COUNT_BITS       = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_op,
  input  logic                     in_bit_value,
  input  logic [7:0]               in_index,
  input  logic                     in_disagree_sel,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [OUT_BITS-1:0]      out_count_value,
  output logic signed [31:0]       out_bit_sum,
  output logic [OUT_BITS-1:0]      out_bits_seen,
  // Configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int PAT_DEPTH = 1 << MAX_PATTERN_BITS;
  localparam int NUM_LAGS  = MAX_LAG_LIMIT + 1;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  // Configuration registers.
  logic [3:0] pattern_length_r;
  logic [4:0] max_lag_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= PATTERN_LENGTH_RESET;
      max_lag_r        <= MAX_LAG_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_PATTERN_LENGTH: pattern_length_r <= pwdata[3:0];
        REG_MAX_LAG:        max_lag_r        <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_PATTERN_LENGTH: prdata = CFG_DATA_BITS'(pattern_length_r);
      REG_MAX_LAG:        prdata = CFG_DATA_BITS'(max_lag_r);
      default:            prdata = '0;
    endcase
  end

  // Input decode.
  op_t  op;
  logic accept;
  logic push;

  assign op     = op_t'(in_op);
  assign accept = in_valid && !in_stall;
  assign push   = accept && (op == OP_PUSH);

  // Stream state.
  logic [31:0]        history_r;
  logic signed [31:0] sum_r;
  cnt_t               total_r;
  logic [31:0]        hist_nxt;

  assign hist_nxt = {history_r[30:0], in_bit_value};

  // Effective pattern length and lag limit after clamping.
  logic [3:0] len;
  logic [4:0] lag_top;

  always_comb begin
    if (pattern_length_r == 4'd0) begin
      len = 4'd1;
    end else if (pattern_length_r > 4'(MAX_PATTERN_BITS)) begin
      len = 4'(MAX_PATTERN_BITS);
    end else begin
      len = pattern_length_r;
    end
    if (max_lag_r > 5'(MAX_LAG_LIMIT)) begin
      lag_top = 5'(MAX_LAG_LIMIT);
    end else begin
      lag_top = max_lag_r;
    end
  end

  // Pattern formed by the newest bits, and the out-of-range check for reads.
  logic [MAX_PATTERN_BITS-1:0] pat;
  logic                        pat_count_en;
  logic                        idx_oob;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN_BITS; i++) begin
      pat[i] = hist_nxt[i] & (4'(i) < len);
    end
    idx_oob = 1'b0;
    for (int i = MAX_PATTERN_BITS; i < 8; i++) begin
      idx_oob = idx_oob | in_index[i];
    end
  end

  assign pat_count_en = total_r >= COUNT_BITS'(len - 4'd1);

  // History, running sum and bit total update on every pushed bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      history_r <= '0;
      sum_r     <= '0;
      total_r   <= '0;
    end else if (push) begin
      history_r <= hist_nxt;
      if (in_bit_value) begin
        if (sum_r != 32'sh7fff_ffff) sum_r <= sum_r + 32'sd1;
      end else begin
        if (sum_r != 32'sh8000_0000) sum_r <= sum_r - 32'sd1;
      end
      if (total_r != '1) total_r <= total_r + cnt_t'(1);
    end
  end

  // Lag lanes: every lag updates its agree or disagree counter in parallel.
  cnt_t lag_agree_r [NUM_LAGS];
  cnt_t lag_dis_r   [NUM_LAGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LAGS; i++) begin
        lag_agree_r[i] <= '0;
        lag_dis_r[i]   <= '0;
      end
    end else if (push) begin
      for (int i = 0; i < NUM_LAGS; i++) begin
        if ((5'(i) <= lag_top) && (total_r >= COUNT_BITS'(i))) begin
          if (hist_nxt[0] ^ hist_nxt[i]) begin
            if (lag_dis_r[i] != '1) lag_dis_r[i] <= lag_dis_r[i] + cnt_t'(1);
          end else begin
            if (lag_agree_r[i] != '1) lag_agree_r[i] <= lag_agree_r[i] + cnt_t'(1);
          end
        end
      end
    end
  end

  // Lag counter selected by a read item.
  cnt_t lag_sel;

  always_comb begin
    lag_sel = '0;
    for (int i = 0; i < NUM_LAGS; i++) begin
      if (in_index[4:0] == 5'(i)) begin
        lag_sel = in_disagree_sel ? lag_dis_r[i] : lag_agree_r[i];
      end
    end
  end

  // Second stage registers.
  logic                        s1_valid_r;
  logic                        s1_push_r;
  logic                        s1_read_r;
  op_t                         s1_op_r;
  logic                        s1_oob_r;
  logic [MAX_PATTERN_BITS-1:0] s1_addr_r;
  cnt_t                        s1_lag_r;
  logic signed [31:0]          s1_sum_r;
  cnt_t                        s1_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_push_r  <= 1'b0;
      s1_read_r  <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s1_push_r  <= push && pat_count_en;
      s1_read_r  <= accept && (op != OP_PUSH);
    end
  end

  logic [MAX_PATTERN_BITS-1:0] pat_raddr;

  assign pat_raddr = (op == OP_PUSH) ? pat : in_index[MAX_PATTERN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= op;
      s1_oob_r   <= idx_oob;
      s1_addr_r  <= pat_raddr;
      s1_lag_r   <= lag_sel;
      s1_sum_r   <= sum_r;
      s1_total_r <= total_r;
    end
  end

  // Pattern counter memory with one write and one registered read port.
  cnt_t pat_mem [PAT_DEPTH];
  logic pat_vld_r [PAT_DEPTH];
  cnt_t pat_rdata_r;
  logic rd_vld_r;
  logic byp_hit_r;
  cnt_t byp_data_r;
  logic pat_we;
  cnt_t pat_old;
  cnt_t pat_wdata;

  assign pat_we    = s1_valid_r && s1_push_r;
  // A write at the edge of the read is not yet in the memory data: forward it.
  assign pat_old   = byp_hit_r ? byp_data_r : (rd_vld_r ? pat_rdata_r : '0);
  assign pat_wdata = (pat_old == '1) ? pat_old : pat_old + cnt_t'(1);

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[s1_addr_r] <= pat_wdata;
    end
    pat_rdata_r <= pat_mem[pat_raddr];
    byp_data_r  <= pat_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAT_DEPTH; i++) begin
        pat_vld_r[i] <= 1'b0;
      end
      rd_vld_r  <= 1'b0;
      byp_hit_r <= 1'b0;
    end else begin
      if (pat_we) begin
        pat_vld_r[s1_addr_r] <= 1'b1;
      end
      rd_vld_r  <= pat_vld_r[pat_raddr];
      byp_hit_r <= pat_we && (s1_addr_r == pat_raddr);
    end
  end

  // Counter value of the read item in the second stage.
  cnt_t s1_count;

  always_comb begin
    case (s1_op_r)
      OP_READ_PATTERN: s1_count = s1_oob_r ? '0 : pat_old;
      OP_READ_LAG:     s1_count = s1_lag_r;
      default:         s1_count = '0;
    endcase
  end

  // Reduce counters to the 32-bit result fields, saturating when COUNT_BITS is wider.
  logic [OUT_BITS-1:0] q_count;
  logic [OUT_BITS-1:0] q_total;

  if (COUNT_BITS > OUT_BITS) begin : g_out_sat
    assign q_count = (|s1_count[COUNT_BITS-1:OUT_BITS]) ? '1 : s1_count[OUT_BITS-1:0];
    assign q_total = (|s1_total_r[COUNT_BITS-1:OUT_BITS]) ? '1 : s1_total_r[OUT_BITS-1:0];
  end else begin : g_out_ext
    assign q_count = OUT_BITS'(s1_count);
    assign q_total = OUT_BITS'(s1_total_r);
  end

  // Two-entry result queue decouples the pipeline from the result stall.
  logic [OUT_BITS-1:0] q_count_r [2];
  logic signed [31:0]  q_sum_r   [2];
  logic [OUT_BITS-1:0] q_total_r [2];
  logic [1:0]          occ_r;
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic                q_push;
  logic                q_pop;
  logic [2:0]          occ_need;

  assign q_push   = s1_valid_r && s1_read_r;
  assign q_pop    = out_valid && !out_stall;
  assign occ_need = 3'(occ_r) + 3'(q_push) - 3'(q_pop);
  assign in_stall = occ_need >= 3'd2;

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_count_r[wr_ptr_r] <= q_count;
      q_sum_r[wr_ptr_r]   <= s1_sum_r;
      q_total_r[wr_ptr_r] <= q_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      occ_r <= 2'(occ_need);
      if (q_push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  assign out_valid       = occ_r != 2'd0;
  assign out_count_value = q_count_r[rd_ptr_r];
  assign out_bit_sum     = q_sum_r[rd_ptr_r];
  assign out_bits_seen   = q_total_r[rd_ptr_r];

  // Checks on the pipeline and the result queue.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= 2'd2)
    else $error("result queue holds more than two items");

  a_no_push_and_read: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_valid_r && s1_push_r && s1_read_r))
    else $error("second stage item both counts a pattern and reads");

  a_bypass_src: assert property (@(posedge clk) disable iff (!rst_n)
    byp_hit_r |-> $past(pat_we))
    else $error("forwarding selected without a write in flight");

  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> total_r >= $past(total_r))
    else $error("bit total decreased");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == 2'd2 && out_stall) |-> in_stall)
    else $error("item accepted while the result queue is full and stalled");

endmodule

/* tb/bit_stream_statistics_collector_tb.sv */
// ---------------------------------------------------------------------------
// Bit stream statistics collector testbench
// Pushes bit streams and read items through the collector under several
// pattern length and lag settings, with random gaps and stalls on both
// channels. A scoreboard keeps its own histogram, lag counters, sum and bit
// total, and checks every read result field by field in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bit_stream_statistics_collector_tb
  import bssc_pkg::*;
();

  localparam int IDLE_PCT    = 31;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 9;

  // One expected read result.
  typedef struct {
    logic [31:0]        count;
    logic signed [31:0] sum;
    logic [31:0]        seen;
  } stats_reply_t;

  // Scoreboard: tracks the collector's statistics and the reads in flight.
  class stream_stats_predictor;
    logic [3:0]         pat_len_reg = PATTERN_LENGTH_RESET;
    logic [4:0]         lag_top_reg = MAX_LAG_RESET;
    logic [31:0]        history = '0;
    logic [31:0]        pattern_hist [256];
    logic [31:0]        lag_hist [64];
    logic signed [31:0] sum = '0;
    logic [31:0]        seen = '0;
    stats_reply_t       awaiting [$];
    int                 mismatches = 0;
    int                 pushes = 0;
    int                 reads = 0;

    function new();
      foreach (pattern_hist[i]) pattern_hist[i] = '0;
      foreach (lag_hist[i]) lag_hist[i] = '0;
    endfunction

    // Pattern length as used: zero acts as one, above eight acts as eight.
    function int unsigned eff_len();
      if (pat_len_reg < 1) return 1;
      if (pat_len_reg > 8) return 8;
      return pat_len_reg;
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function void set_reg(reg_idx_t r, logic [31:0] v);
      if (r == REG_PATTERN_LENGTH) pat_len_reg = v[3:0];
      else lag_top_reg = v[4:0];
    endfunction

    function void push_bit(logic b);
      int unsigned len;
      int unsigned mask;
      logic [31:0] pat;
      logic        d;
      len = eff_len();
      mask = (1 << len) - 1;
      history = {history[30:0], b};
      if (seen >= len - 1) begin
        pat = history & mask;
        pattern_hist[pat[7:0]] = bump(pattern_hist[pat[7:0]]);
      end
      // Every lag with enough history; lag zero always agrees.
      for (int t = 0; t <= lag_top_reg; t++) begin
        if (seen >= t) begin
          d = history[0] ^ history[5'(t)];
          lag_hist[{5'(t), d}] = bump(lag_hist[{5'(t), d}]);
        end
      end
      // The sum holds at its signed bounds.
      if (b) begin
        if (sum != 32'sh7FFF_FFFF) sum = sum + 32'sd1;
      end else begin
        if (sum != 32'sh8000_0000) sum = sum - 32'sd1;
      end
      seen = bump(seen);
    endfunction

    // Called for every accepted input item.
    function void note_item(op_t op, logic b, logic [7:0] idx, logic sel);
      stats_reply_t r;
      if (op == OP_PUSH) begin
        push_bit(b);
        pushes++;
        return;
      end
      case (op)
        OP_READ_PATTERN: r.count = pattern_hist[idx];
        OP_READ_LAG:     r.count = lag_hist[{idx[4:0], sel}];
        default:         r.count = '0;
      endcase
      r.sum = sum;
      r.seen = seen;
      awaiting.push_back(r);
      reads++;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("Mismatch: %s", msg);
    endfunction

    // Called for every accepted result item.
    function void check_result(logic [31:0] count, logic signed [31:0] s,
                               logic [31:0] n);
      stats_reply_t r;
      if (awaiting.size() == 0) begin
        flag($sformatf("result with none expected: count %0h sum %0d seen %0d",
                       count, s, n));
        return;
      end
      r = awaiting.pop_front();
      if (count !== r.count)
        flag($sformatf("count_value expected %0h got %0h", r.count, count));
      if (s !== r.sum)
        flag($sformatf("bit_sum expected %0d got %0d", r.sum, s));
      if (n !== r.seen)
        flag($sformatf("bits_seen expected %0d got %0d", r.seen, n));
    endfunction

    function void close_out();
      if (awaiting.size() != 0)
        flag($sformatf("%0d results never arrived", awaiting.size()));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_op = OP_PUSH;
  logic               in_bit_value = 1'b0;
  logic [7:0]         in_index = '0;
  logic               in_disagree_sel = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        out_count_value;
  logic signed [31:0] out_bit_sum;
  logic [31:0]        out_bits_seen;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic               pready;

  stream_stats_predictor sb = new();
  int  cycles = 0;
  int  settings = 0;
  bit  calm = 1'b0;

  bit_stream_statistics_collector dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_bit_value(in_bit_value), .in_index(in_index),
    .in_disagree_sel(in_disagree_sel),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_count_value(out_count_value), .out_bit_sum(out_bit_sum),
    .out_bits_seen(out_bits_seen),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side stalls at random, except in the calm stretch.
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_count_value, out_bit_sum, out_bits_seen);
  end

  // Offer one item after a random gap and hold it until it is taken.
  task automatic send_item(op_t op, logic b, logic [7:0] idx, logic sel);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_bit_value <= b;
    in_index <= idx;
    in_disagree_sel <= sel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(op, b, idx, sel);
  endtask

  // Stop sending and wait for every pending result; optionally let the
  // pattern memory write in flight finish as well.
  task automatic quiesce(bit with_tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaiting.size() != 0) @(posedge clk);
    if (with_tail) repeat (4) @(posedge clk);
  endtask

  // Register write with random upper data bits, which the block ignores.
  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    logic [31:0] word;
    word = $urandom;
    if (r == REG_PATTERN_LENGTH) word[3:0] = v[3:0];
    else word[4:0] = v[4:0];
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    sb.set_reg(r, word);
    settings++;
  endtask

  task automatic set_mode(int len, int lag);
    quiesce(1'b1);
    write_reg(REG_PATTERN_LENGTH, len);
    write_reg(REG_MAX_LAG, lag);
  endtask

  // Mostly pushes, with occasional runs of one value, mixed with reads.
  task automatic run_random(int n);
    int          roll;
    int          run_left;
    logic        run_bit;
    logic        b;
    logic [7:0]  idx;
    int unsigned mask;
    run_left = 0;
    run_bit = 1'b0;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 58) begin
        if (run_left == 0 && $urandom_range(9) == 0) begin
          run_left = $urandom_range(12, 3);
          run_bit = 1'($urandom_range(1));
        end
        if (run_left != 0) begin
          b = run_bit;
          run_left--;
        end else begin
          b = 1'($urandom_range(1));
        end
        send_item(OP_PUSH, b, 8'($urandom), 1'($urandom));
      end else if (roll < 75) begin
        mask = (1 << sb.eff_len()) - 1;
        idx = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom & mask);
        send_item(OP_READ_PATTERN, 1'($urandom), idx, 1'($urandom));
      end else if (roll < 92) begin
        send_item(OP_READ_LAG, 1'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        send_item(OP_READ_SUM, 1'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    int phase_len [PHASES] = '{3, 1, 8, 12, 0, 5, 15, 2, 7};
    int phase_lag [PHASES] = '{5, 31, 0, 17, 31, 2, 31, 10, 0};
    logic [7:0] first_pat [8] = '{1, 1, 0, 1, 0, 0, 1, 1};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reads straight after reset, with unused index bits set.
    send_item(OP_READ_PATTERN, 1'b0, 8'h00, 1'b0);
    send_item(OP_READ_PATTERN, 1'b1, 8'hFF, 1'b1);
    send_item(OP_READ_LAG, 1'b0, 8'h00, 1'b0);
    send_item(OP_READ_LAG, 1'b1, 8'hFF, 1'b1);
    send_item(OP_READ_SUM, 1'b1, 8'hFF, 1'b1);

    // Eight bits under the reset setting: exactly one full pattern.
    foreach (first_pat[i]) send_item(OP_PUSH, first_pat[i][0], 8'hFF, 1'b1);
    send_item(OP_READ_PATTERN, 1'b0, 8'hD3, 1'b0);
    send_item(OP_READ_LAG, 1'b0, 8'h00, 1'b0);
    send_item(OP_READ_LAG, 1'b0, 8'h00, 1'b1);
    send_item(OP_READ_LAG, 1'b0, 8'h07, 1'b0);
    send_item(OP_READ_SUM, 1'b0, 8'h00, 1'b0);

    // Pattern length zero acts as one; only lag zero is updated.
    set_mode(0, 0);
    send_item(OP_PUSH, 1'b0, 8'h00, 1'b0);
    send_item(OP_PUSH, 1'b1, 8'h00, 1'b0);
    send_item(OP_READ_PATTERN, 1'b0, 8'h01, 1'b0);
    send_item(OP_READ_PATTERN, 1'b0, 8'hD3, 1'b0);
    send_item(OP_READ_LAG, 1'b0, 8'h01, 1'b0);

    // Pattern length above eight acts as eight.
    set_mode(13, 31);
    send_item(OP_PUSH, 1'b1, 8'h00, 1'b0);
    send_item(OP_READ_PATTERN, 1'b0, 8'hA7, 1'b0);
    send_item(OP_READ_SUM, 1'b0, 8'h00, 1'b0);

    // Random phases over a spread of settings.
    for (int p = 0; p < PHASES; p++) begin
      set_mode(phase_len[p], phase_lag[p]);
      calm = (p == 4);
      if (p == 6) begin
        run_random(23);
        quiesce(1'b0);
        run_random(24);
      end else begin
        run_random(47);
      end
    end
    calm = 1'b0;

    quiesce(1'b1);
    sb.close_out();
    $display("Run covered %0d pushed bits and %0d reads over %0d register writes,",
             sb.pushes, sb.reads, settings);
    $display("with random gaps and stalls on both channels and one stretch free of them.");
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches in total", sb.mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
